@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("concurrent assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concurrent assertion failed");

`endif

@@ rtl/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm clock with snooze - package
// Word types, operation codes, constants and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

    localparam int HOURS_PER_DAY  = 24;
    localparam int MINS_PER_HOUR  = 60;
    localparam int MINS_PER_DAY   = HOURS_PER_DAY * MINS_PER_HOUR;
    localparam int MINUTE_STEP    = 5;
    localparam int OFFSET_MAX     = MINS_PER_DAY;
    localparam int SNOOZE_RESET   = 9;
    // x / 60 == (x * DIV60_MUL) >> DIV60_SHIFT for x below one day
    localparam int DIV60_MUL      = 2185;
    localparam int DIV60_SHIFT    = 17;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_HOUR_UP     = 4'd1,
        OP_HOUR_DOWN   = 4'd2,
        OP_MIN_UP      = 4'd3,
        OP_MIN_DOWN    = 4'd4,
        OP_TOGGLE_ARM  = 4'd5,
        OP_SET_ALARM   = 4'd6,
        OP_SNOOZE      = 4'd7,
        OP_CLEAR_SNOOZE = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0] operation;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_in_word;

    typedef struct packed {
        logic       fired;
        logic [4:0] alarm_hour_out;
        logic [5:0] alarm_minute_out;
        logic       armed_out;
        logic       snoozing_out;
        logic [4:0] next_hour;
        logic [5:0] next_minute;
    } t_out_word;

    typedef struct packed {
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic        armed;
        logic        snoozing;
        logic [10:0] offset;
    } t_alarm_state;

    // hour * 60 + minute, as shift and subtract
    function automatic logic [11:0] mins_of(input logic [4:0] h, input logic [5:0] m);
        logic [11:0] h64;
        logic [11:0] h4;
        h64 = {1'b0, h, 6'b0};
        h4  = {5'b0, h, 2'b0};
        return h64 - h4 + {6'b0, m};
    endfunction

endpackage

`default_nettype wire

@@ rtl/acs_update.sv @@
// ----------------------------------------------------------------------------
// Alarm clock with snooze - state update
// Alarm state and snooze length registers, operation decode, fire detection.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_update
    import acs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_wdata,
    input  wire logic         i_adv,
    input  wire t_in_word     i_word,
    output t_alarm_state      o_state,
    output logic              o_fired
);

    t_alarm_state r_state;
    t_alarm_state n_state;
    logic [7:0]   r_snooze_minutes;

    logic [11:0]  sum;
    logic [10:0]  sat;
    logic [11:0]  tgt;
    logic [11:0]  now;
    logic         late;
    logic         fired;

    always_comb begin
        sum  = {1'b0, r_state.offset} + {4'b0, r_snooze_minutes};
        sat  = (sum > 12'(OFFSET_MAX)) ? 11'(OFFSET_MAX) : sum[10:0];
        tgt  = mins_of(r_state.alarm_hour, r_state.alarm_minute) + {1'b0, r_state.offset};
        now  = mins_of(i_word.hour, i_word.minute);
        // target seconds <= now seconds, seconds field may exceed 59
        late = (tgt <= now) ||
               ((tgt == now + 12'd1) && (i_word.second >= 6'(MINS_PER_HOUR)));

        n_state = r_state;
        fired   = 1'b0;
        case (t_op'(i_word.operation))
            OP_TICK: begin
                if (r_state.armed) begin
                    if (i_word.hour == r_state.alarm_hour &&
                        i_word.minute == r_state.alarm_minute &&
                        !r_state.snoozing && i_word.second == 6'd0) begin
                        n_state.offset   = sat;
                        n_state.snoozing = 1'b1;
                        fired            = 1'b1;
                    end else if (r_state.snoozing && late) begin
                        n_state.offset = sat;
                        fired          = 1'b1;
                    end
                end
            end
            OP_HOUR_UP: begin
                n_state.alarm_hour = (r_state.alarm_hour >= 5'(HOURS_PER_DAY - 1)) ?
                                     5'd0 : r_state.alarm_hour + 5'd1;
            end
            OP_HOUR_DOWN: begin
                n_state.alarm_hour = (r_state.alarm_hour == 5'd0) ?
                                     5'(HOURS_PER_DAY - 1) : r_state.alarm_hour - 5'd1;
            end
            OP_MIN_UP: begin
                n_state.alarm_minute =
                    (r_state.alarm_minute >= 6'(MINS_PER_HOUR - MINUTE_STEP)) ?
                    r_state.alarm_minute - 6'(MINS_PER_HOUR - MINUTE_STEP) :
                    r_state.alarm_minute + 6'(MINUTE_STEP);
            end
            OP_MIN_DOWN: begin
                n_state.alarm_minute =
                    (r_state.alarm_minute < 6'(MINUTE_STEP)) ?
                    r_state.alarm_minute + 6'(MINS_PER_HOUR - MINUTE_STEP) :
                    r_state.alarm_minute - 6'(MINUTE_STEP);
            end
            OP_TOGGLE_ARM: begin
                n_state.armed = !r_state.armed;
            end
            OP_SET_ALARM: begin
                if (i_word.hour <= 5'(HOURS_PER_DAY - 1) &&
                    i_word.minute <= 6'(MINS_PER_HOUR - 1)) begin
                    n_state.alarm_hour   = i_word.hour;
                    n_state.alarm_minute = i_word.minute;
                end
            end
            OP_SNOOZE: begin
                if (!r_state.snoozing) begin
                    n_state.offset = sat;
                end
                n_state.snoozing = 1'b1;
            end
            OP_CLEAR_SNOOZE: begin
                n_state.offset   = 11'd0;
                n_state.snoozing = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= '0;
            r_snooze_minutes <= 8'(SNOOZE_RESET);
        end else begin
            if (i_adv) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_snooze_minutes <= i_cfg_wdata;
            end
        end
    end

    assign o_state = n_state;
    assign o_fired = fired;

endmodule

`default_nettype wire

@@ rtl/acs_disp.sv @@
// ----------------------------------------------------------------------------
// Alarm clock with snooze - next alarm time
// Alarm time plus snooze offset, wrapped once, split into hour and minute.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_disp
    import acs_pkg::*;
(
    input  wire t_alarm_state i_state,
    output logic [4:0]        o_next_hour,
    output logic [5:0]        o_next_minute
);

    logic [11:0] total;
    logic [10:0] wrapped;
    logic [21:0] prod;
    logic [4:0]  hr;
    logic [11:0] rem;

    always_comb begin
        total   = mins_of(i_state.alarm_hour, i_state.alarm_minute) + {1'b0, i_state.offset};
        wrapped = (total >= 12'(MINS_PER_DAY)) ? 11'(total - 12'(MINS_PER_DAY)) : total[10:0];
        // divide by 60 through the reciprocal
        prod    = {11'b0, wrapped} * 22'(DIV60_MUL);
        hr      = 5'(prod >> DIV60_SHIFT);
        rem     = {1'b0, wrapped} - mins_of(hr, 6'd0);
    end

    assign o_next_hour   = hr;
    assign o_next_minute = rem[5:0];

endmodule

`default_nettype wire

@@ rtl/alarm_clock_with_snooze_core.sv @@
// Alarm clock with snooze, top level.
// Path: a word taken into the input register moves on to the result register
//   when the result register is free; a stall holds it in the input register.
// Throughput: one word per cycle while the output does not stall; input and
//   result registers with decode, fire check and offset conversion between them.
// Reset: synchronous, active low; clears alarm state, flags and offset,
//   loads snooze length 9 and empties both registers.
// ----------------------------------------------------------------------------
// Alarm clock with snooze - core
// Valid/stall handshake, input register, state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_with_snooze_core
    import acs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_word   i_word,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_word       o_word,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    logic         r_in_valid;
    t_in_word     r_in_word;
    logic         r_out_valid;
    t_out_word    r_out_word;

    logic         out_free;
    logic         adv;
    t_alarm_state n_state;
    logic         n_fired;
    logic [4:0]   n_hour;
    logic [5:0]   n_minute;
    t_out_word    n_out_word;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    acs_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_word      (r_in_word),
        .o_state     (n_state),
        .o_fired     (n_fired)
    );

    acs_disp u_disp (
        .i_state       (n_state),
        .o_next_hour   (n_hour),
        .o_next_minute (n_minute)
    );

    always_comb begin
        n_out_word.fired            = n_fired;
        n_out_word.alarm_hour_out   = n_state.alarm_hour;
        n_out_word.alarm_minute_out = n_state.alarm_minute;
        n_out_word.armed_out        = n_state.armed;
        n_out_word.snoozing_out     = n_state.snoozing;
        n_out_word.next_hour        = n_hour;
        n_out_word.next_minute      = n_minute;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word <= i_word;
        end
        if (adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

`default_nettype wire

@@ rtl/acs_checker.sv @@
// ----------------------------------------------------------------------------
// Alarm clock with snooze - port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module acs_checker
    import acs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word i_out_word
);

    `ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `ASSERT_NEXT(a_word_held, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_word))
    `ASSERT_ALWAYS(a_fire_flags, i_clk, i_rst_n, !(i_out_valid && i_out_word.fired) || (i_out_word.armed_out && i_out_word.snoozing_out))
    `ASSERT_ALWAYS(a_time_range, i_clk, i_rst_n, !i_out_valid || (i_out_word.alarm_hour_out <= 5'd23 && i_out_word.alarm_minute_out <= 6'd59 && i_out_word.next_hour <= 5'd23 && i_out_word.next_minute <= 6'd59))

endmodule

bind alarm_clock_with_snooze_core acs_checker u_acs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_word  (o_word)
);

`default_nettype wire

@@ sim/tb_alarm_clock_with_snooze_core.sv @@
// ----------------------------------------------------------------------------
// Alarm clock with snooze - testbench
// Drives alarm words through the core under several sender and receiver
// idling patterns and snooze lengths, predicts every result word and checks
// each one field by field against the predicted stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_alarm_clock_with_snooze_core;
    import acs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_WORDS = 400;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    class alarm_board;
        logic [7:0]  snooze_len;
        logic [4:0]  al_hour;
        logic [5:0]  al_min;
        logic        armed;
        logic        snoozing;
        logic [10:0] offset;
        t_out_word   due_results[$];
        int          errors;
        int          words_in;
        int          fires;

        function void clear_state();
            snooze_len = 8'(SNOOZE_RESET);
            al_hour    = '0;
            al_min     = '0;
            armed      = 1'b0;
            snoozing   = 1'b0;
            offset     = '0;
            due_results.delete();
            errors     = 0;
            words_in   = 0;
            fires      = 0;
        endfunction

        function void lengthen_snooze();
            int sum;
            sum = int'(offset) + int'(snooze_len);
            offset = (sum > OFFSET_MAX) ? 11'(OFFSET_MAX) : 11'(sum);
        endfunction

        function bit tick_fires(int h, int m, int s);
            int now_s;
            int target_s;
            if (!armed)
                return 1'b0;
            if (h == int'(al_hour) && m == int'(al_min) && !snoozing && s == 0) begin
                lengthen_snooze();
                snoozing = 1'b1;
                return 1'b1;
            end
            if (snoozing) begin
                now_s    = h * 3600 + m * 60 + s;
                target_s = int'(al_hour) * 3600 + int'(al_min) * 60 + int'(offset) * 60;
                if (target_s <= now_s) begin
                    lengthen_snooze();
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void accept_word(t_in_word w);
            t_out_word exp_w;
            int        total;
            exp_w = '0;
            case (w.operation)
                OP_TICK: exp_w.fired = tick_fires(w.hour, w.minute, w.second);
                OP_HOUR_UP: al_hour = (al_hour == 5'(HOURS_PER_DAY - 1)) ? 5'd0 : al_hour + 5'd1;
                OP_HOUR_DOWN: al_hour = (al_hour == 5'd0) ? 5'(HOURS_PER_DAY - 1) : al_hour - 5'd1;
                OP_MIN_UP: al_min = 6'((int'(al_min) + MINUTE_STEP) % MINS_PER_HOUR);
                OP_MIN_DOWN:
                    al_min = 6'((int'(al_min) + MINS_PER_HOUR - MINUTE_STEP) % MINS_PER_HOUR);
                OP_TOGGLE_ARM: armed = !armed;
                OP_SET_ALARM: begin
                    if (w.hour < HOURS_PER_DAY && w.minute < MINS_PER_HOUR) begin
                        al_hour = w.hour;
                        al_min  = w.minute;
                    end
                end
                OP_SNOOZE: begin
                    if (!snoozing)
                        lengthen_snooze();
                    snoozing = 1'b1;
                end
                OP_CLEAR_SNOOZE: begin
                    offset   = '0;
                    snoozing = 1'b0;
                end
                default: ;
            endcase
            total = int'(al_hour) * MINS_PER_HOUR + int'(al_min) + int'(offset);
            if (total >= MINS_PER_DAY)
                total -= MINS_PER_DAY;
            exp_w.alarm_hour_out   = al_hour;
            exp_w.alarm_minute_out = al_min;
            exp_w.armed_out        = armed;
            exp_w.snoozing_out     = snoozing;
            exp_w.next_hour        = 5'(total / MINS_PER_HOUR);
            exp_w.next_minute      = 6'(total % MINS_PER_HOUR);
            if (exp_w.fired)
                fires++;
            words_in++;
            due_results.push_back(exp_w);
        endfunction

        function void match_result(t_out_word got);
            t_out_word exp_w;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result word %h with nothing outstanding", got);
                return;
            end
            exp_w = due_results.pop_front();
            if (got.fired !== exp_w.fired ||
                got.alarm_hour_out !== exp_w.alarm_hour_out ||
                got.alarm_minute_out !== exp_w.alarm_minute_out ||
                got.armed_out !== exp_w.armed_out ||
                got.snoozing_out !== exp_w.snoozing_out ||
                got.next_hour !== exp_w.next_hour ||
                got.next_minute !== exp_w.next_minute) begin
                errors++;
                if (errors <= 10) begin
                    $display("word mismatch: exp fired=%0d alarm=%0d:%0d arm=%0d snz=%0d next=%0d:%0d",
                             exp_w.fired, exp_w.alarm_hour_out, exp_w.alarm_minute_out,
                             exp_w.armed_out, exp_w.snoozing_out, exp_w.next_hour,
                             exp_w.next_minute);
                    $display("               got fired=%0d alarm=%0d:%0d arm=%0d snz=%0d next=%0d:%0d",
                             got.fired, got.alarm_hour_out, got.alarm_minute_out,
                             got.armed_out, got.snoozing_out, got.next_hour,
                             got.next_minute);
                end
            end
        endfunction

        function void close_out();
            if (due_results.size() != 0) begin
                errors++;
                $display("%0d result words never arrived", due_results.size());
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_word   i_word;
    logic       o_valid;
    logic       i_stall;
    t_out_word  o_word;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    alarm_board board;
    int         idle_pct;
    int         stall_pct;
    int         cycles;

    alarm_clock_with_snooze_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        cycles      = 0;
    end

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.match_result(o_word);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.accept_word(w);
    endtask

    task automatic send_fields(input logic [3:0] op, input logic [4:0] h,
                               input logic [5:0] m, input logic [5:0] s);
        t_in_word w;
        w.operation = op;
        w.hour      = h;
        w.minute    = m;
        w.second    = s;
        send_word(w);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_snooze_len(input logic [7:0] len);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.snooze_len = len;
    endtask

    // ticks aimed at the alarm minute or the snooze target, then controls and noise
    function automatic t_in_word pick_word();
        t_in_word w;
        int       sel;
        int       tgt;
        sel = int'($urandom_range(0, 99));
        w.operation = OP_TICK;
        w.second    = 6'($urandom_range(0, 59));
        w.hour      = '0;
        w.minute    = '0;
        if (sel < 30) begin
            w.hour   = board.al_hour;
            w.minute = board.al_min;
            if ($urandom_range(0, 1) != 0)
                w.second = '0;
        end else if (sel < 55) begin
            tgt = int'(board.al_hour) * MINS_PER_HOUR + int'(board.al_min)
                + int'(board.offset) + int'($urandom_range(0, 2)) - 1;
            if (tgt < 0 || tgt >= MINS_PER_DAY)
                tgt = int'($urandom_range(0, MINS_PER_DAY - 1));
            w.hour   = 5'(tgt / MINS_PER_HOUR);
            w.minute = 6'(tgt % MINS_PER_HOUR);
        end else if (sel < 80) begin
            w.operation = 4'($urandom_range(OP_HOUR_UP, OP_CLEAR_SNOOZE));
            w.hour      = 5'($urandom_range(0, 23));
            w.minute    = 6'($urandom_range(0, 59));
            if (w.operation == OP_SET_ALARM && $urandom_range(0, 7) == 0) begin
                w.hour   = 5'($urandom_range(0, 31));
                w.minute = 6'($urandom_range(0, 63));
            end
        end else begin
            w = 21'($urandom);
        end
        return w;
    endfunction

    initial begin
        t_in_word   w;
        int         useful;
        bit         paused;
        int         phase;
        logic [7:0] len;

        board = new;
        board.clear_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_fields(OP_TICK, 0, 0, 0);
        send_fields(OP_HOUR_DOWN, 0, 0, 0);
        send_fields(OP_HOUR_UP, 0, 0, 0);
        send_fields(OP_MIN_DOWN, 0, 0, 0);
        send_fields(OP_MIN_UP, 0, 0, 0);
        send_fields(OP_SET_ALARM, 24, 30, 0);
        send_fields(OP_SET_ALARM, 5, 60, 0);
        send_fields(OP_SET_ALARM, 31, 63, 63);
        send_fields(OP_SET_ALARM, 23, 59, 0);
        send_fields(OP_MIN_UP, 0, 0, 0);
        send_fields(OP_HOUR_UP, 0, 0, 0);
        send_fields(OP_SET_ALARM, 23, 50, 0);
        send_fields(OP_TOGGLE_ARM, 0, 0, 0);
        send_fields(OP_TICK, 23, 50, 1);
        send_fields(OP_TICK, 23, 50, 0);
        // second snooze lands beyond midnight
        send_fields(OP_TICK, 23, 59, 59);
        send_fields(OP_TICK, 23, 59, 59);
        send_fields(OP_TICK, 31, 63, 63);
        send_fields(OP_SNOOZE, 0, 0, 0);
        send_fields(OP_CLEAR_SNOOZE, 0, 0, 0);
        send_fields(OP_SNOOZE, 0, 0, 0);
        send_fields(OP_TOGGLE_ARM, 0, 0, 0);
        send_fields(OP_TICK, 31, 63, 63);
        send_fields(OP_UNUSED_LO, 31, 63, 63);
        send_fields(OP_UNUSED_HI, 0, 0, 0);
        send_fields(OP_CLEAR_SNOOZE, 0, 0, 0);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin len = 8'd255; idle_pct = 0;  stall_pct = 0;  end
                1: begin len = 8'd0;   idle_pct = 84; stall_pct = 0;  end
                2: begin len = 8'($urandom_range(1, 254)); idle_pct = 0; stall_pct = 84; end
                default: begin len = 8'd1; idle_pct = 9; stall_pct = 9; end
            endcase
            write_snooze_len(len);
            useful = 0;
            paused = 1'b0;
            while (useful < PHASE_WORDS) begin
                w = pick_word();
                send_word(w);
                if (w.operation <= OP_CLEAR_SNOOZE)
                    useful++;
                if (!paused && useful == PHASE_WORDS / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        board.close_out();
        $display("%0d words checked, %0d alarm fires seen", board.words_in, board.fires);
        $display("snooze lengths 9, 255, 0, one random and 1; four idling patterns");
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
